// ----- rtl/core/tlbpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, types and structs of the TLB / page map translation block.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	localparam int TLB_SLOTS   = 16;
	localparam int SLOT_W      = $clog2(TLB_SLOTS);
	localparam int PAGE_COUNT  = 256;
	localparam int PAGE_W      = $clog2(PAGE_COUNT);
	localparam int FRAME_COUNT = 256;
	localparam int FRAME_W     = $clog2(FRAME_COUNT);
	localparam int OFFSET_BITS = 8;
	localparam int VA_W        = 16;
	localparam int PA_W        = 16;
	localparam int CNT_W       = 32;
	localparam int FRAMES_W    = 9;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(256);
	localparam logic [FRAMES_W-1:0] FRAME_CAP    = FRAMES_W'(FRAME_COUNT);

	typedef logic [PAGE_W-1:0]      page_t;
	typedef logic [FRAME_W-1:0]     frame_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [CNT_W-1:0]       count_t;

	typedef struct packed {
		logic   en;
		page_t  page;
		frame_t frame;
	} tlb_ins_t;

	typedef struct packed {
		logic   hit;
		frame_t frame;
	} tlb_look_t;

	function automatic count_t bump(input count_t c);
		bump = (c == '1) ? c : c + count_t'(1);
	endfunction

endpackage

// ----- rtl/core/tlbpt_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_ifs
// Valid/ready channels of the translation block: request, response, config.
// ----------------------------------------------------------------------------
interface tlbpt_req_if;
	logic                        valid;
	logic                        ready;
	logic [tlbpt_pkg::VA_W-1:0]  virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tlbpt_pkg::PA_W-1:0]  physical_address;
	logic                        tlb_hit;
	logic                        page_fault;
	logic                        no_free_frame;
	logic [tlbpt_pkg::CNT_W-1:0] translated_count;
	logic [tlbpt_pkg::CNT_W-1:0] fault_count;
	logic [tlbpt_pkg::CNT_W-1:0] hit_count;

	modport source (output valid, output physical_address, output tlb_hit,
		output page_fault, output no_free_frame, output translated_count,
		output fault_count, output hit_count, input ready);
	modport sink (input valid, input physical_address, input tlb_hit,
		input page_fault, input no_free_frame, input translated_count,
		input fault_count, input hit_count, output ready);
endinterface

interface tlbpt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tlbpt_pkg::FRAMES_W-1:0] frames_in_use;

	modport source (output valid, output frames_in_use, input ready);
	modport sink   (input valid, input frames_in_use, output ready);
endinterface

// ----- rtl/core/tlbpt_tlb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB with parallel compare and round-robin (FIFO) refill.
// ----------------------------------------------------------------------------
module tlbpt_tlb (
	input  logic                clk,
	input  logic                arst_n,
	input  tlbpt_pkg::page_t    page,
	output tlbpt_pkg::tlb_look_t look,
	input  tlbpt_pkg::tlb_ins_t ins
);

	logic [tlbpt_pkg::TLB_SLOTS-1:0] valid_q;
	tlbpt_pkg::page_t                page_q  [tlbpt_pkg::TLB_SLOTS];
	tlbpt_pkg::frame_t               frame_q [tlbpt_pkg::TLB_SLOTS];
	logic [tlbpt_pkg::SLOT_W-1:0]    slot_q;
	logic [tlbpt_pkg::TLB_SLOTS-1:0] match;

	always_comb begin
		for (int i = 0; i < tlbpt_pkg::TLB_SLOTS; i++) begin
			match[i] = valid_q[i] && (page_q[i] == page);
		end
	end

	// lowest matching slot wins
	always_comb begin
		look.hit   = 1'b0;
		look.frame = '0;
		for (int i = tlbpt_pkg::TLB_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				look.hit   = 1'b1;
				look.frame = frame_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
		end else if (ins.en) begin
			valid_q[slot_q] <= 1'b1;
			slot_q          <= slot_q + tlbpt_pkg::SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ins.en) begin
			page_q[slot_q]  <= ins.page;
			frame_q[slot_q] <= ins.frame;
		end
	end

endmodule

// ----- rtl/core/tlb_page_table_translate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translate
// Virtual to physical translation: TLB lookup, page map read on miss,
// frame allocation on page fault, FIFO TLB refill and saturating counters.
// A request word waits in busy_s1 while its page map read is registered, then
// its result goes to the response register, held while a response is untaken;
// the map/TLB update completes before the next word is accepted and read.
// A response word waiting in the output register does not block a new request.
// Reset clears TLB valid bits, map valid bits, counters and the free-frame
// pointer at once; frames_in_use returns to 256. No clearing pass.
// ----------------------------------------------------------------------------
module tlb_page_table_translate (
	input  logic        clk,
	input  logic        arst_n,
	tlbpt_req_if.sink   req,
	tlbpt_rsp_if.source rsp,
	tlbpt_cfg_if.sink   cfg
);

	logic [tlbpt_pkg::FRAMES_W-1:0]   frames_in_use_q;
	logic [tlbpt_pkg::FRAMES_W-1:0]   next_free_q;
	logic [tlbpt_pkg::PAGE_COUNT-1:0] map_valid_q;
	tlbpt_pkg::frame_t                map_mem [tlbpt_pkg::PAGE_COUNT];
	tlbpt_pkg::frame_t                map_rd_s1;
	logic                             busy_s1;
	tlbpt_pkg::page_t                 page_s1;
	tlbpt_pkg::offset_t               off_s1;
	tlbpt_pkg::count_t                addr_cnt_q;
	tlbpt_pkg::count_t                fault_cnt_q;
	tlbpt_pkg::count_t                hit_cnt_q;
	logic                             rsp_valid_q;

	logic                             accept;
	logic                             done;
	tlbpt_pkg::page_t                 req_page;
	tlbpt_pkg::tlb_look_t             look;
	tlbpt_pkg::tlb_ins_t              ins;
	logic                             map_hit;
	logic                             fault;
	logic                             alloc;
	logic                             none;
	logic [tlbpt_pkg::FRAMES_W-1:0]   cap;
	tlbpt_pkg::frame_t                frame;

	assign cfg.ready = 1'b1;
	assign req.ready = !busy_s1;
	assign accept    = req.valid && !busy_s1;
	assign req_page  = req.virtual_address[tlbpt_pkg::OFFSET_BITS +: tlbpt_pkg::PAGE_W];
	assign done      = busy_s1 && (!rsp_valid_q || rsp.ready);

	tlbpt_tlb u_tlb (
		.clk    (clk),
		.arst_n (arst_n),
		.page   (page_s1),
		.look   (look),
		.ins    (ins)
	);

	always_comb begin
		map_hit = map_valid_q[page_s1];
		cap     = (frames_in_use_q > tlbpt_pkg::FRAME_CAP) ? tlbpt_pkg::FRAME_CAP
			: frames_in_use_q;
		fault   = !look.hit && !map_hit;
		alloc   = fault && (next_free_q < cap);
		none    = fault && !alloc;
		priority if (look.hit) begin
			frame = look.frame;
		end else if (map_hit) begin
			frame = map_rd_s1;
		end else begin
			frame = next_free_q[tlbpt_pkg::FRAME_W-1:0];
		end
		ins.en    = done && !look.hit && !none;
		ins.page  = page_s1;
		ins.frame = frame;
	end

	// page map: one write, one registered read
	always_ff @(posedge clk) begin
		if (done && alloc) begin
			map_mem[page_s1] <= frame;
		end
		if (accept) begin
			map_rd_s1 <= map_mem[req_page];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= tlbpt_pkg::FRAMES_RESET;
			next_free_q     <= '0;
			map_valid_q     <= '0;
			busy_s1         <= 1'b0;
			addr_cnt_q      <= '0;
			fault_cnt_q     <= '0;
			hit_cnt_q       <= '0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				frames_in_use_q <= cfg.frames_in_use;
			end
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
				addr_cnt_q  <= tlbpt_pkg::bump(addr_cnt_q);
				if (fault) begin
					fault_cnt_q <= tlbpt_pkg::bump(fault_cnt_q);
				end
				if (look.hit) begin
					hit_cnt_q <= tlbpt_pkg::bump(hit_cnt_q);
				end
				if (alloc) begin
					map_valid_q[page_s1] <= 1'b1;
					next_free_q          <= next_free_q + tlbpt_pkg::FRAMES_W'(1);
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= req_page;
			off_s1  <= req.virtual_address[tlbpt_pkg::OFFSET_BITS-1:0];
		end
		if (done) begin
			rsp.physical_address <= none ? '0 : {frame, off_s1};
			rsp.tlb_hit          <= look.hit;
			rsp.page_fault       <= fault;
			rsp.no_free_frame    <= none;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.translated_count = addr_cnt_q;
	assign rsp.fault_count      = fault_cnt_q;
	assign rsp.hit_count        = hit_cnt_q;

	a_nofree_is_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp.no_free_frame |-> rsp.page_fault && rsp.physical_address == '0)
		else $error("no_free_frame without page fault or with nonzero address");

	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp.tlb_hit && rsp.page_fault))
		else $error("TLB hit and page fault together");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= tlbpt_pkg::FRAME_CAP)
		else $error("free-frame pointer beyond frame pool");

	a_alloc_advance: assert property (@(posedge clk) disable iff (!arst_n)
		done && alloc |=> next_free_q == $past(next_free_q) + tlbpt_pkg::FRAMES_W'(1))
		else $error("free-frame pointer did not advance on allocation");

	a_no_read_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && !done |=> busy_s1 && $stable(page_s1))
		else $error("pending item lost before completion");

endmodule
